// ===== sv/isp_pkg.sv =====
// Shared types and constants for the interval slot profiler.
// Used by the controller, the datapath, the top level and the port checker.
package isp_pkg;

    // Fixed field widths of the event and result transactions
    localparam int CMD_W        = 1;
    localparam int TICK_W       = 48;
    localparam int TYPE_FIELD_W = 6;
    localparam int SLOT_FIELD_W = 8;
    localparam int COUNT_W      = 32;
    localparam int TOTAL_W      = 64;
    localparam int OPEN_FIELD_W = 9;
    localparam int STATUS_W     = 2;

    // Event commands
    localparam logic [CMD_W-1:0] CMD_START = 1'b0;
    localparam logic [CMD_W-1:0] CMD_STOP  = 1'b1;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK        = 2'd0,
        STATUS_NO_FREE   = 2'd1,
        STATUS_NONE_OPEN = 2'd2
    } status_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic capture;       // latch an accepted event
        logic clear;         // clear one per-type entry
        logic start_commit;  // open a slot and report it
        logic start_err;     // report a start with no free slot
        logic stop_err;      // report a stop with nothing open
        logic stop_commit;   // close a slot, update per-type stores, report
    } isp_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic is_stop;       // captured event is a stop
        logic full;          // every slot is open
        logic empty;         // no slot is open
        logic clear_last;    // clearing pass is at its last entry
    } isp_status_t;

endpackage

// ===== sv/isp_ctrl.sv =====
// Controller for the interval slot profiler: sequences clearing, lookup and
// accumulation. Depends on isp_pkg for the command and status structs.
module isp_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  isp_pkg::isp_status_t stat,
    output isp_pkg::isp_cmd_t    cmd,
    output logic                 busy
);
    import isp_pkg::*;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOK,
        ST_ACC
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   busy_reg;

    // Decode next state and datapath commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (stat.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                priority if (!stat.is_stop && stat.full)
                begin
                    cmd.start_err = 1'b1;
                    state_next    = ST_IDLE;
                end
                else if (!stat.is_stop)
                begin
                    cmd.start_commit = 1'b1;
                    state_next       = ST_IDLE;
                end
                else if (stat.empty)
                begin
                    cmd.stop_err = 1'b1;
                    state_next   = ST_IDLE;
                end
                else
                begin
                    state_next = ST_ACC;
                end
            end
            ST_ACC:
            begin
                cmd.stop_commit = 1'b1;
                state_next      = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state and the registered busy flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            busy_reg  <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= (state_next != ST_IDLE);
        end
    end

    assign busy = busy_reg;

endmodule

// ===== sv/isp_datapath.sv =====
// Datapath for the interval slot profiler: free-slot ring, slot stores,
// per-type stores, pointers and result registers. Depends on isp_pkg.
module isp_datapath #(
    parameter int SLOTS = 256,
    parameter int TYPES = 64
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  isp_pkg::isp_cmd_t                    cmd,
    output isp_pkg::isp_status_t                 stat,
    input  logic [isp_pkg::CMD_W-1:0]            command,
    input  logic [isp_pkg::TICK_W-1:0]           now_ticks,
    input  logic [isp_pkg::TYPE_FIELD_W-1:0]     thread_type,
    input  logic [isp_pkg::SLOT_FIELD_W-1:0]     slot,
    output logic                                 done,
    output logic [isp_pkg::SLOT_FIELD_W-1:0]     slot_out,
    output logic [isp_pkg::TICK_W-1:0]           elapsed_ticks,
    output logic [isp_pkg::COUNT_W-1:0]          type_count,
    output logic [isp_pkg::TOTAL_W-1:0]          type_total_ticks,
    output logic [isp_pkg::OPEN_FIELD_W-1:0]     open_count,
    output logic [isp_pkg::STATUS_W-1:0]         status
);
    import isp_pkg::*;

    localparam int SLOT_W = $clog2(SLOTS);
    localparam int CAT_W  = (TYPES > 1) ? $clog2(TYPES) : 1;
    localparam int OPEN_W = $clog2(SLOTS + 1);
    localparam int SR_W   = SLOT_FIELD_W + SLOT_W + 1;
    localparam int TR_W   = TYPE_FIELD_W + CAT_W + 1;

    // Reduce a slot field modulo SLOTS by restoring subtraction
    function automatic logic [SLOT_W-1:0] reduce_slot(input logic [SLOT_FIELD_W-1:0] v);
        logic [SR_W-1:0] r;
        logic [SR_W-1:0] d;
        r = SR_W'(v);
        for (int k = SLOT_FIELD_W - 1; k >= 0; k--)
        begin
            d = SR_W'(SLOTS) << k;
            if (r >= d)
            begin
                r = r - d;
            end
        end
        return SLOT_W'(r);
    endfunction

    // Reduce a thread type modulo TYPES by restoring subtraction
    function automatic logic [CAT_W-1:0] reduce_type(input logic [TYPE_FIELD_W-1:0] v);
        logic [TR_W-1:0] r;
        logic [TR_W-1:0] d;
        r = TR_W'(v);
        for (int k = TYPE_FIELD_W - 1; k >= 0; k--)
        begin
            d = TR_W'(TYPES) << k;
            if (r >= d)
            begin
                r = r - d;
            end
        end
        return CAT_W'(r);
    endfunction

    // Memories
    logic [SLOT_W-1:0]  ring_mem  [SLOTS];
    logic [TICK_W-1:0]  start_mem [SLOTS];
    logic [CAT_W-1:0]   cat_mem   [SLOTS];
    logic [TOTAL_W-1:0] tot_mem   [TYPES];
    logic [COUNT_W-1:0] cnt_mem   [TYPES];

    // Control registers
    logic [SLOT_W-1:0] get_ptr_reg;
    logic [SLOT_W-1:0] put_ptr_reg;
    logic              ring_wrapped_reg;
    logic [OPEN_W-1:0] open_reg;
    logic [CAT_W-1:0]  clr_addr_reg;
    logic              done_reg;

    // Captured event
    logic [CMD_W-1:0]  cmd_reg;
    logic [TICK_W-1:0] now_reg;
    logic [CAT_W-1:0]  ttype_reg;
    logic [SLOT_W-1:0] slot_reg;

    // Memory read data and intermediate results
    logic [SLOT_W-1:0]  ring_rd_reg;
    logic               ring_written_reg;
    logic [TICK_W-1:0]  start_rd_reg;
    logic [CAT_W-1:0]   cat_rd_reg;
    logic [TOTAL_W-1:0] tot_rd_reg;
    logic [COUNT_W-1:0] cnt_rd_reg;
    logic [TICK_W-1:0]  el_reg;
    logic [CAT_W-1:0]   cat_reg;

    // Result registers
    logic [SLOT_FIELD_W-1:0] slot_out_reg;
    logic [TICK_W-1:0]       elapsed_reg;
    logic [COUNT_W-1:0]      count_out_reg;
    logic [TOTAL_W-1:0]      total_out_reg;
    logic [OPEN_FIELD_W-1:0] open_out_reg;
    status_t                 status_reg;

    logic [SLOT_W-1:0]  slot_in_idx;
    logic [SLOT_W-1:0]  start_slot;
    logic [TOTAL_W:0]   tot_sum;
    logic [TOTAL_W-1:0] tot_new;
    logic [COUNT_W-1:0] cnt_new;

    assign slot_in_idx = reduce_slot(slot);

    // Ring entries never written still hold their own index
    assign start_slot = ring_written_reg ? ring_rd_reg : get_ptr_reg;

    // Saturating per-type update
    assign tot_sum = {1'b0, tot_rd_reg} + (TOTAL_W + 1)'(el_reg);
    assign tot_new = tot_sum[TOTAL_W] ? '1 : tot_sum[TOTAL_W-1:0];
    assign cnt_new = (cnt_rd_reg == '1) ? cnt_rd_reg : cnt_rd_reg + 1'b1;

    assign stat.is_stop    = (cmd_reg == CMD_STOP);
    assign stat.full       = (open_reg == OPEN_W'(SLOTS));
    assign stat.empty      = (open_reg == '0);
    assign stat.clear_last = (clr_addr_reg == CAT_W'(TYPES - 1));

    // Register the done flag and advance pointers, open count and clearing address
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            get_ptr_reg      <= '0;
            put_ptr_reg      <= '0;
            ring_wrapped_reg <= 1'b0;
            open_reg         <= '0;
            clr_addr_reg     <= '0;
            done_reg         <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.start_commit | cmd.start_err | cmd.stop_err | cmd.stop_commit;
            if (cmd.clear)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            if (cmd.start_commit)
            begin
                get_ptr_reg <= (get_ptr_reg == SLOT_W'(SLOTS - 1)) ? '0 : get_ptr_reg + 1'b1;
                open_reg    <= open_reg + 1'b1;
            end
            if (cmd.stop_commit)
            begin
                if (put_ptr_reg == SLOT_W'(SLOTS - 1))
                begin
                    put_ptr_reg      <= '0;
                    ring_wrapped_reg <= 1'b1;
                end
                else
                begin
                    put_ptr_reg <= put_ptr_reg + 1'b1;
                end
                open_reg <= open_reg - 1'b1;
            end
        end
    end

    // Latch the accepted transaction
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            cmd_reg   <= command;
            now_reg   <= now_ticks;
            ttype_reg <= reduce_type(thread_type);
            slot_reg  <= slot_in_idx;
        end
    end

    // Free-slot ring: read at the get pointer, return closed slots at the put pointer
    always_ff @(posedge clk)
    begin
        ring_rd_reg      <= ring_mem[get_ptr_reg];
        ring_written_reg <= ring_wrapped_reg || (get_ptr_reg < put_ptr_reg);
        if (cmd.stop_commit)
        begin
            ring_mem[put_ptr_reg] <= slot_reg;
        end
    end

    // Slot stores: read at the incoming slot, write on start
    always_ff @(posedge clk)
    begin
        start_rd_reg <= start_mem[slot_in_idx];
        cat_rd_reg   <= cat_mem[slot_in_idx];
        if (cmd.start_commit)
        begin
            start_mem[start_slot] <= now_reg;
            cat_mem[start_slot]   <= ttype_reg;
        end
    end

    // Elapsed ticks and category of the slot being closed
    always_ff @(posedge clk)
    begin
        el_reg  <= now_reg - start_rd_reg;
        cat_reg <= cat_rd_reg;
    end

    // Per-type stores: clear after reset, update on stop
    always_ff @(posedge clk)
    begin
        tot_rd_reg <= tot_mem[cat_rd_reg];
        cnt_rd_reg <= cnt_mem[cat_rd_reg];
        if (cmd.clear)
        begin
            tot_mem[clr_addr_reg] <= '0;
            cnt_mem[clr_addr_reg] <= '0;
        end
        else if (cmd.stop_commit)
        begin
            tot_mem[cat_reg] <= tot_new;
            cnt_mem[cat_reg] <= cnt_new;
        end
    end

    // Load the result registers
    always_ff @(posedge clk)
    begin
        if (cmd.start_commit)
        begin
            slot_out_reg  <= SLOT_FIELD_W'(start_slot);
            elapsed_reg   <= '0;
            count_out_reg <= '0;
            total_out_reg <= '0;
            open_out_reg  <= OPEN_FIELD_W'(open_reg + 1'b1);
            status_reg    <= STATUS_OK;
        end
        else if (cmd.start_err)
        begin
            slot_out_reg  <= '0;
            elapsed_reg   <= '0;
            count_out_reg <= '0;
            total_out_reg <= '0;
            open_out_reg  <= OPEN_FIELD_W'(open_reg);
            status_reg    <= STATUS_NO_FREE;
        end
        else if (cmd.stop_err)
        begin
            slot_out_reg  <= '0;
            elapsed_reg   <= '0;
            count_out_reg <= '0;
            total_out_reg <= '0;
            open_out_reg  <= '0;
            status_reg    <= STATUS_NONE_OPEN;
        end
        else if (cmd.stop_commit)
        begin
            slot_out_reg  <= SLOT_FIELD_W'(slot_reg);
            elapsed_reg   <= el_reg;
            count_out_reg <= cnt_new;
            total_out_reg <= tot_new;
            open_out_reg  <= OPEN_FIELD_W'(open_reg - 1'b1);
            status_reg    <= STATUS_OK;
        end
    end

    assign done             = done_reg;
    assign slot_out         = slot_out_reg;
    assign elapsed_ticks    = elapsed_reg;
    assign type_count       = count_out_reg;
    assign type_total_ticks = total_out_reg;
    assign open_count       = open_out_reg;
    assign status           = status_reg;

endmodule

// ===== sv/interval_slot_profiler.sv =====
// Top level of the interval slot profiler: controller plus datapath.
// Depends on isp_pkg, isp_ctrl and isp_datapath.
//
// Issue an event by raising start while busy is low; the transaction is taken
// at that clock edge. A start needs a registered read of the free-slot ring
// and a stop a registered read of the slot store, and a stop adds a
// registered read-modify-write of the per-type total and count stores. The
// result appears on the result ports for exactly one cycle with done high;
// there is no way to hold it off, so capture it when done is seen. A new
// event may be issued in the same cycle that done is high. After reset the
// block stays busy while it clears the per-type stores.
module interval_slot_profiler #(
    parameter int SLOTS = 256,
    parameter int TYPES = 64
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [isp_pkg::CMD_W-1:0]        command,
    input  logic [isp_pkg::TICK_W-1:0]       now_ticks,
    input  logic [isp_pkg::TYPE_FIELD_W-1:0] thread_type,
    input  logic [isp_pkg::SLOT_FIELD_W-1:0] slot,
    output logic                             done,
    output logic [isp_pkg::SLOT_FIELD_W-1:0] slot_out,
    output logic [isp_pkg::TICK_W-1:0]       elapsed_ticks,
    output logic [isp_pkg::COUNT_W-1:0]      type_count,
    output logic [isp_pkg::TOTAL_W-1:0]      type_total_ticks,
    output logic [isp_pkg::OPEN_FIELD_W-1:0] open_count,
    output logic [isp_pkg::STATUS_W-1:0]     status
);
    import isp_pkg::*;

    isp_cmd_t    cmd;
    isp_status_t stat;

    // Sequence the event
    isp_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    // Hold the stores and compute results
    isp_datapath #(
        .SLOTS (SLOTS),
        .TYPES (TYPES)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .stat             (stat),
        .command          (command),
        .now_ticks        (now_ticks),
        .thread_type      (thread_type),
        .slot             (slot),
        .done             (done),
        .slot_out         (slot_out),
        .elapsed_ticks    (elapsed_ticks),
        .type_count       (type_count),
        .type_total_ticks (type_total_ticks),
        .open_count       (open_count),
        .status           (status)
    );

endmodule

// ===== sv/isp_checker.sv =====
// Port-level checks for the interval slot profiler, bound to the top level.
// Depends on isp_pkg and interval_slot_profiler.
module isp_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             start,
    input logic                             busy,
    input logic                             done,
    input logic [isp_pkg::SLOT_FIELD_W-1:0] slot_out,
    input logic [isp_pkg::TICK_W-1:0]       elapsed_ticks,
    input logic [isp_pkg::COUNT_W-1:0]      type_count,
    input logic [isp_pkg::TOTAL_W-1:0]      type_total_ticks,
    input logic [isp_pkg::STATUS_W-1:0]     status
);
    import isp_pkg::*;

    // An accepted transaction makes the block busy in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
    else $error("busy not raised after an accepted transaction");

    // No result in the cycle right after a transaction is accepted
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> !done)
    else $error("result issued too early");

    // A result only follows a busy cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
    else $error("result without preceding work");

    // A rejected event reports zero payload
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != STATUS_OK) |->
            (slot_out == '0 && elapsed_ticks == '0 && type_count == '0
             && type_total_ticks == '0))
    else $error("rejected event carries payload");

endmodule

bind interval_slot_profiler isp_checker u_isp_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .done             (done),
    .slot_out         (slot_out),
    .elapsed_ticks    (elapsed_ticks),
    .type_count       (type_count),
    .type_total_ticks (type_total_ticks),
    .status           (status)
);

// ===== tb/interval_slot_profiler_tb.sv =====
// Self-checking testbench for interval_slot_profiler: directed table, full-ring
// fill and drain, random start/stop traffic and a burst of maximal intervals on one type.
// Depends on isp_pkg and the interval_slot_profiler RTL.
module interval_slot_profiler_tb;
    import isp_pkg::*;

    localparam int SLOTS            = 256;
    localparam int TYPES            = 64;
    localparam int RANDOM_PER_PHASE = 440;
    localparam int BURST_PAIRS      = 60;
    localparam int CYCLE_LIMIT      = 3_000_000;
    localparam int N_DIR            = 14;
    localparam bit [TICK_W-1:0] TICK_MAX = '1;

    // One event transaction and one result transaction
    typedef struct packed {
        logic [CMD_W-1:0]        cmd;
        bit   [TICK_W-1:0]       now;
        bit   [TYPE_FIELD_W-1:0] ttype;
        bit   [SLOT_FIELD_W-1:0] slot_id;
    } event_t;

    typedef struct packed {
        bit   [SLOT_FIELD_W-1:0] slot_id;
        bit   [TICK_W-1:0]       elapsed;
        bit   [COUNT_W-1:0]      count;
        bit   [TOTAL_W-1:0]      total;
        bit   [OPEN_FIELD_W-1:0] open_slots;
        status_t                 code;
    } profile_rec_t;

    typedef struct packed {
        event_t       ev;
        bit           known;
        profile_rec_t want;
    } vector_t;

    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    start;
    logic                    busy;
    logic [CMD_W-1:0]        command;
    logic [TICK_W-1:0]       now_ticks;
    logic [TYPE_FIELD_W-1:0] thread_type;
    logic [SLOT_FIELD_W-1:0] slot;
    logic                    done;
    logic [SLOT_FIELD_W-1:0] slot_out;
    logic [TICK_W-1:0]       elapsed_ticks;
    logic [COUNT_W-1:0]      type_count;
    logic [TOTAL_W-1:0]      type_total_ticks;
    logic [OPEN_FIELD_W-1:0] open_count;
    logic [STATUS_W-1:0]     status;

    // Profiler state as the testbench predicts it
    bit [SLOT_FIELD_W-1:0] free_ring   [SLOTS];
    bit [SLOT_FIELD_W-1:0] put_ptr;
    bit [SLOT_FIELD_W-1:0] get_ptr;
    int                    open_n;
    bit [TICK_W-1:0]       slot_start  [SLOTS];
    bit [TYPE_FIELD_W-1:0] slot_type   [SLOTS];
    bit [TOTAL_W-1:0]      type_total  [TYPES];
    bit [COUNT_W-1:0]      type_done   [TYPES];
    bit                    ever_opened [SLOTS];

    profile_rec_t          pending_results [$];
    bit [SLOT_FIELD_W-1:0] open_q [$];
    int                    idle_pct;
    int                    mismatch_cnt;
    int                    results_seen;
    int                    cycle_cnt;
    int                    n_start_ok;
    int                    n_stop_ok;
    int                    n_no_free;
    int                    n_none_open;

    // Directed rows: expected result typed in where it is obvious
    vector_t directed_tbl [N_DIR] = '{
        '{'{CMD_STOP,  TICK_MAX, 6'd63, 8'hFF}, 1'b1,
          '{8'd0, 48'd0, 32'd0, 64'd0, 9'd0, STATUS_NONE_OPEN}},
        '{'{CMD_START, 48'd0, 6'd0, 8'd0}, 1'b1,
          '{8'd0, 48'd0, 32'd0, 64'd0, 9'd1, STATUS_OK}},
        '{'{CMD_START, TICK_MAX, 6'd63, 8'hFF}, 1'b1,
          '{8'd1, 48'd0, 32'd0, 64'd0, 9'd2, STATUS_OK}},
        '{'{CMD_START, 48'h8000_0000_0000, 6'h2A, 8'h55}, 1'b1,
          '{8'd2, 48'd0, 32'd0, 64'd0, 9'd3, STATUS_OK}},
        '{'{CMD_STOP,  TICK_MAX, 6'd0, 8'd0}, 1'b1,
          '{8'd0, TICK_MAX, 32'd1, 64'h0000_FFFF_FFFF_FFFF, 9'd2, STATUS_OK}},
        '{'{CMD_STOP,  48'd0, 6'h3F, 8'd1}, 1'b1,
          '{8'd1, 48'd1, 32'd1, 64'd1, 9'd1, STATUS_OK}},
        '{'{CMD_STOP,  48'h8000_0000_0000, 6'd0, 8'd2}, 1'b1,
          '{8'd2, 48'd0, 32'd1, 64'd0, 9'd0, STATUS_OK}},
        '{'{CMD_STOP,  48'h1234, 6'h15, 8'hAA}, 1'b1,
          '{8'd0, 48'd0, 32'd0, 64'd0, 9'd0, STATUS_NONE_OPEN}},
        '{'{CMD_START, 48'd5, 6'd63, 8'd0}, 1'b1,
          '{8'd3, 48'd0, 32'd0, 64'd0, 9'd1, STATUS_OK}},
        '{'{CMD_STOP,  48'd7, 6'd0, 8'd1}, 1'b0, '0},
        '{'{CMD_START, 48'h5555_5555_5555, 6'h15, 8'hAA}, 1'b0, '0},
        '{'{CMD_STOP,  48'd4, 6'h2A, 8'd3}, 1'b0, '0},
        '{'{CMD_START, 48'hAAAA_AAAA_AAAA, 6'h2A, 8'h55}, 1'b0, '0},
        '{'{CMD_STOP,  48'd1, 6'h15, 8'd5}, 1'b0, '0}
    };

    interval_slot_profiler #(
        .SLOTS(SLOTS),
        .TYPES(TYPES)
    ) uut (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .command          (command),
        .now_ticks        (now_ticks),
        .thread_type      (thread_type),
        .slot             (slot),
        .done             (done),
        .slot_out         (slot_out),
        .elapsed_ticks    (elapsed_ticks),
        .type_count       (type_count),
        .type_total_ticks (type_total_ticks),
        .open_count       (open_count),
        .status           (status)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Return the predicted profiler state to its reset contents
    function automatic void profile_reset();
        for (int i = 0; i < SLOTS; i++)
        begin
            free_ring[i]   = SLOT_FIELD_W'(i);
            slot_start[i]  = '0;
            slot_type[i]   = '0;
            ever_opened[i] = 1'b0;
        end
        for (int i = 0; i < TYPES; i++)
        begin
            type_total[i] = '0;
            type_done[i]  = '0;
        end
        put_ptr = '0;
        get_ptr = '0;
        open_n  = 0;
    endfunction

    // Apply one event to the predicted state and return its result.
    // Field widths equal SLOTS and TYPES, so index reduction is implicit.
    function automatic profile_rec_t profile_event(input event_t ev);
        profile_rec_t          r;
        bit [SLOT_FIELD_W-1:0] s;
        bit [TYPE_FIELD_W-1:0] c;
        bit [TICK_W-1:0]       el;
        bit [TOTAL_W:0]        sum;
        r      = '0;
        r.code = STATUS_OK;
        if (ev.cmd == CMD_START)
        begin
            if (open_n == SLOTS)
            begin
                r.open_slots = OPEN_FIELD_W'(open_n);
                r.code       = STATUS_NO_FREE;
            end
            else
            begin
                s             = free_ring[get_ptr];
                slot_start[s] = ev.now;
                slot_type[s]  = ev.ttype;
                get_ptr       = get_ptr + 1'b1;
                open_n++;
                r.slot_id     = s;
                r.open_slots  = OPEN_FIELD_W'(open_n);
            end
        end
        else if (open_n == 0)
        begin
            r.code = STATUS_NONE_OPEN;
        end
        else
        begin
            s   = ev.slot_id;
            el  = ev.now - slot_start[s];
            c   = slot_type[s];
            sum = {1'b0, type_total[c]} + {{(TOTAL_W+1-TICK_W){1'b0}}, el};
            // Saturate the total and the count
            type_total[c] = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
            if (type_done[c] != '1)
                type_done[c] = type_done[c] + 1'b1;
            free_ring[put_ptr] = s;
            put_ptr            = put_ptr + 1'b1;
            open_n--;
            r.slot_id    = s;
            r.elapsed    = el;
            r.count      = type_done[c];
            r.total      = type_total[c];
            r.open_slots = OPEN_FIELD_W'(open_n);
        end
        return r;
    endfunction

    // Pick any slot that has been opened at least once
    function automatic bit [SLOT_FIELD_W-1:0] pick_written();
        bit [SLOT_FIELD_W-1:0] s;
        s = SLOT_FIELD_W'($urandom_range(SLOTS - 1));
        while (!ever_opened[s])
            s = SLOT_FIELD_W'($urandom_range(SLOTS - 1));
        return s;
    endfunction

    // Build a random event; stops mostly close an open slot
    task automatic random_event(output event_t ev);
        bit [63:0]   w;
        int unsigned roll;
        w      = {$urandom(), $urandom()};
        ev.now = w[TICK_W-1:0];
        roll   = $urandom_range(99);
        if (roll < 10)
            ev.now = TICK_W'($urandom_range(15));
        else if (roll < 20)
            ev.now = TICK_MAX - TICK_W'($urandom_range(15));
        if ($urandom_range(1) == 1)
            ev.ttype = TYPE_FIELD_W'($urandom_range(3));
        else
            ev.ttype = TYPE_FIELD_W'($urandom_range(TYPES - 1));
        ev.slot_id = SLOT_FIELD_W'($urandom_range(SLOTS - 1));
        roll       = $urandom_range(99);
        if (open_n == 0)
            ev.cmd = (roll < 85) ? CMD_START : CMD_STOP;
        else if (open_n == SLOTS)
            ev.cmd = (roll < 80) ? CMD_STOP : CMD_START;
        else
            ev.cmd = (roll < 50) ? CMD_START : CMD_STOP;
        if (ev.cmd == CMD_STOP && open_n != 0)
        begin
            if ($urandom_range(99) < 10 || open_q.size() == 0)
                ev.slot_id = pick_written();
            else
                ev.slot_id = open_q[$urandom_range(open_q.size() - 1)];
        end
    endtask

    // Drop start and hold until every outstanding result has arrived
    task automatic wait_drained();
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Drive one event transaction, wait for acceptance, predict and maybe idle
    task automatic send(input event_t ev, input bit known, input profile_rec_t typed);
        profile_rec_t got;
        command     <= ev.cmd;
        now_ticks   <= ev.now;
        thread_type <= ev.ttype;
        slot        <= ev.slot_id;
        start       <= 1'b1;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        got = profile_event(ev);
        pending_results.push_back(known ? typed : got);
        // Track which slots are open so later stops stay legal
        if (got.code == STATUS_NO_FREE)
            n_no_free++;
        else if (got.code == STATUS_NONE_OPEN)
            n_none_open++;
        else if (ev.cmd == CMD_START)
        begin
            n_start_ok++;
            ever_opened[got.slot_id] = 1'b1;
            open_q.push_back(got.slot_id);
        end
        else
        begin
            n_stop_ok++;
            for (int i = 0; i < open_q.size(); i++)
            begin
                if (open_q[i] == got.slot_id)
                begin
                    open_q.delete(i);
                    break;
                end
            end
        end
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    function automatic void check_field(input string name, input bit [63:0] want,
                                        input logic [63:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            mismatch_cnt++;
        end
    endfunction

    // Compare each result transaction with the oldest expectation
    always @(posedge clk)
    begin : result_check
        profile_rec_t want;
        if (rst_n === 1'b1 && done === 1'b1)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with no transaction outstanding: slot_out %0h status %0h",
                       slot_out, status);
                mismatch_cnt++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("slot_out", 64'(want.slot_id), 64'(slot_out));
                check_field("elapsed_ticks", 64'(want.elapsed), 64'(elapsed_ticks));
                check_field("type_count", 64'(want.count), 64'(type_count));
                check_field("type_total_ticks", want.total, type_total_ticks);
                check_field("open_count", 64'(want.open_slots), 64'(open_count));
                check_field("status", 64'(want.code), 64'(status));
                results_seen++;
            end
        end
    end

    // Bound the run
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin : stimulus
        event_t                ev;
        bit [SLOT_FIELD_W-1:0] s0;
        bit [TICK_W-1:0]       t0;
        bit [TYPE_FIELD_W-1:0] sat_type;
        bit [63:0]             w;
        int                    n_saturated;
        rst_n        = 1'b0;
        start        = 1'b0;
        command      = CMD_START;
        now_ticks    = '0;
        thread_type  = '0;
        slot         = '0;
        idle_pct     = 38;
        mismatch_cnt = 0;
        results_seen = 0;
        cycle_cnt    = 0;
        n_start_ok   = 0;
        n_stop_ok    = 0;
        n_no_free    = 0;
        n_none_open  = 0;
        profile_reset();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Walk the directed table
        for (int i = 0; i < N_DIR; i++)
            send(directed_tbl[i].ev, directed_tbl[i].known, directed_tbl[i].want);
        wait_drained();

        // Fill every slot, overflow, then drain past empty
        while (open_n < SLOTS)
        begin
            random_event(ev);
            ev.cmd = CMD_START;
            send(ev, 1'b0, '0);
        end
        repeat (3)
        begin
            random_event(ev);
            ev.cmd = CMD_START;
            send(ev, 1'b0, '0);
        end
        while (open_n > 0)
        begin
            random_event(ev);
            ev.cmd = CMD_STOP;
            if (open_q.size() != 0)
                ev.slot_id = open_q[$urandom_range(open_q.size() - 1)];
            else
                ev.slot_id = pick_written();
            send(ev, 1'b0, '0);
        end
        repeat (3)
        begin
            random_event(ev);
            ev.cmd = CMD_STOP;
            send(ev, 1'b0, '0);
        end

        // Random traffic under three sender idle settings
        for (int phase = 0; phase < 3; phase++)
        begin
            idle_pct = (phase == 0) ? 38 : (phase == 1) ? 45 : 0;
            for (int n = 0; n < RANDOM_PER_PHASE; n++)
            begin
                random_event(ev);
                send(ev, 1'b0, '0);
            end
            wait_drained();
        end

        // Pile maximal intervals onto one type total: repeat a stale stop on
        // one slot, each start reusing the same timestamp and type
        if (open_n == SLOTS)
        begin
            random_event(ev);
            ev.cmd     = CMD_STOP;
            ev.slot_id = pick_written();
            send(ev, 1'b0, '0);
        end
        w          = {$urandom(), $urandom()};
        t0         = w[TICK_W-1:0];
        sat_type   = TYPE_FIELD_W'($urandom_range(TYPES - 1));
        ev.ttype   = sat_type;
        ev.slot_id = '0;
        ev.cmd     = CMD_START;
        ev.now     = t0;
        send(ev, 1'b0, '0);
        s0 = open_q[open_q.size() - 1];
        for (int n = 0; n < BURST_PAIRS; n++)
        begin
            ev.cmd     = CMD_STOP;
            ev.now     = t0 - 1'b1;
            ev.slot_id = s0;
            send(ev, 1'b0, '0);
            ev.cmd = CMD_START;
            ev.now = t0;
            send(ev, 1'b0, '0);
        end

        // Let the last results arrive, then watch for strays
        wait_drained();
        repeat (10) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            $error("%0d expected results never arrived", pending_results.size());
            mismatch_cnt++;
        end

        n_saturated = 0;
        for (int i = 0; i < TYPES; i++)
            if (type_total[i] == '1)
                n_saturated++;
        $display("Checked %0d results: %0d starts, %0d stops, %0d full-ring rejects,",
                 results_seen, n_start_ok, n_stop_ok, n_no_free);
        $display("%0d empty rejects; ring filled and drained; %0d type totals saturated",
                 n_none_open, n_saturated);
        $display("%0d mismatches", mismatch_cnt);
        if (mismatch_cnt == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== files.f =====
sv/isp_pkg.sv
sv/isp_ctrl.sv
sv/isp_datapath.sv
sv/interval_slot_profiler.sv
sv/isp_checker.sv
tb/interval_slot_profiler_tb.sv
